>>> rtl/sort_loaded_block_ascending_top_macros.svh
// Assertion macros used by the block sorter datapath.
`ifndef SORT_LOADED_BLOCK_ASCENDING_TOP_MACROS_SVH
`define SORT_LOADED_BLOCK_ASCENDING_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slba assertion failed");

// Next-cycle implication, checked outside reset.
`define SLBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slba assertion failed");

`endif

>>> rtl/slba_pkg.sv
// Package: shared constants, controller states and command/status structs.
`timescale 1ns / 1ps
package slba_pkg;

  localparam int VALUE_W       = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_PASS_START,
    ST_PASS_FIRST,
    ST_PASS_RUN,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMIT_HOLD
  } state_t;

  typedef struct packed {
    logic load_item;
    logic setup_sort;
    logic pass_first;
    logic pass_step;
    logic pass_close;
    logic rd_next;
    logic emit_load;
    logic emit_next;
    logic block_done;
  } dp_cmd_t;

  typedef struct packed {
    logic count_le1;
    logic pass_at_end;
    logic last_pass;
    logic out_taken;
    logic out_is_last;
  } dp_status_t;

endpackage

>>> rtl/slba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module slba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/slba_ctrl.sv
// Controller: sequences load, bubble passes and result emission.
`timescale 1ns / 1ps
module slba_ctrl import slba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last_item,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       in_ready
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (in_last_item) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup_sort = 1'b1;
        state_nxt      = status.count_le1 ? ST_EMIT_RD : ST_PASS_START;
      end
      ST_PASS_START: begin
        state_nxt = ST_PASS_FIRST;
      end
      ST_PASS_FIRST: begin
        cmd.pass_first = 1'b1;
        cmd.rd_next    = 1'b1;
        state_nxt      = ST_PASS_RUN;
      end
      ST_PASS_RUN: begin
        cmd.pass_step = 1'b1;
        cmd.rd_next   = 1'b1;
        if (status.pass_at_end) begin
          state_nxt = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        cmd.pass_close = 1'b1;
        state_nxt      = status.last_pass ? ST_EMIT_RD : ST_PASS_START;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        cmd.emit_load = 1'b1;
        state_nxt     = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (status.out_taken) begin
          if (status.out_is_last) begin
            cmd.block_done = 1'b1;
            state_nxt      = ST_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

>>> rtl/slba_dp.sv
// Datapath: element store, counters, bubble carry register and output register.
`timescale 1ns / 1ps
`include "sort_loaded_block_ascending_top_macros.svh"
module slba_dp import slba_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [VALUE_W-1:0]  out_sorted_value,
  output logic                out_last_out,
  output logic                out_overflow
);

  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               dropped_r, dropped_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0]  pass_end_r, pass_end_nxt;
  logic [VALUE_W-1:0] carry_r, carry_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic carry_gt;
  logic out_taken;
  logic emit_last;

  slba_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign carry_gt  = $signed(carry_r) > $signed(ram_rdata);
  assign out_taken = out_valid_r & out_ready;
  assign emit_last = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));
  assign ram_raddr = cmd.rd_next ? (idx_r + ADDR_W'(1)) : idx_r;

  always_comb begin
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    idx_nxt       = idx_r;
    pass_end_nxt  = pass_end_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = carry_r;

    if (cmd.load_item) begin
      if (count_r < CNT_FULL) begin
        ram_we    = 1'b1;
        ram_waddr = count_r[ADDR_W-1:0];
        ram_wdata = in_value;
        count_nxt = count_r + CNT_W'(1);
      end else begin
        dropped_nxt = 1'b1;
      end
    end

    if (cmd.setup_sort) begin
      pass_end_nxt = ADDR_W'(count_r - CNT_W'(1));
      idx_nxt      = '0;
    end

    if (cmd.pass_first) begin
      carry_nxt = ram_rdata;
      idx_nxt   = idx_r + ADDR_W'(1);
    end

    // Carry the running maximum forward; write the smaller one back one slot lower.
    if (cmd.pass_step) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r - ADDR_W'(1);
      ram_wdata = carry_gt ? ram_rdata : carry_r;
      if (!carry_gt) begin
        carry_nxt = ram_rdata;
      end
      idx_nxt = idx_r + ADDR_W'(1);
    end

    if (cmd.pass_close) begin
      ram_we       = 1'b1;
      ram_waddr    = pass_end_r;
      ram_wdata    = carry_r;
      pass_end_nxt = pass_end_r - ADDR_W'(1);
      idx_nxt      = '0;
    end

    if (out_taken) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = ram_rdata;
      out_last_nxt  = emit_last;
      out_ovf_nxt   = dropped_r;
    end

    if (cmd.emit_next) begin
      idx_nxt = idx_r + ADDR_W'(1);
    end

    if (cmd.block_done) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      idx_r       <= '0;
      pass_end_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      idx_r       <= idx_nxt;
      pass_end_r  <= pass_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r     <= carry_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign status.count_le1   = (count_r <= CNT_W'(1));
  assign status.pass_at_end = (idx_r == pass_end_r);
  assign status.last_pass   = (pass_end_r == ADDR_W'(1));
  assign status.out_taken   = out_taken;
  assign status.out_is_last = out_last_r;

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

  `SLBA_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_FULL)
  `SLBA_ASSERT_NEXT(a_drop_when_full, cmd.load_item && (count_r == CNT_FULL), dropped_r)
  `SLBA_ASSERT_IMPL(a_step_in_range, cmd.pass_step, (idx_r != '0) && (idx_r <= pass_end_r))

endmodule

>>> rtl/sort_loaded_block_ascending_top.sv
// Load takes one item per cycle; after the last item, the store is sorted by
// bubble passes, one compare per cycle. Each result is then read from the store,
// loaded into the output register and held until taken; the next block loads after
// the last result is taken. Throughput is set by the pass loop over the store's one
// read port and one write port. Reset (rst_n low, synchronous) clears the count,
// drop flag, index, pass end, state and output valid; store contents are not
// cleared and are only read after being written.
`timescale 1ns / 1ps
module sort_loaded_block_ascending_top import slba_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_last_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_sorted_value,
  output logic               out_last_out,
  output logic               out_overflow
);

  // Controller and datapath talk only through these two bundles.
  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence: take items until the one flagged last, then run shrinking
  // bubble passes over the store, then stream the store out in order.
  slba_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .status       (status),
    .cmd          (cmd),
    .in_ready     (in_ready)
  );

  // Hold the store, the counters and the result register. Items past
  // capacity are dropped and flag every result of the block.
  slba_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_value         (in_value),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule
